FILE: hw/rtl/tcar_pkg.sv
// Shared types and constants for the text cell attribute renderer.
`default_nettype none

package tcar_pkg;

    // Character cell geometry
    localparam int CELL_LINES = 14;
    localparam int LINE_W     = 4;
    localparam logic [LINE_W-1:0] UNDERLINE_LINE = LINE_W'(CELL_LINES - 1);
    localparam logic [LINE_W-1:0] CURSOR_LINE    = LINE_W'(CELL_LINES - 2);

    // Payload widths
    localparam int BYTE_W = 8;
    localparam int DOTS_W = 9;
    localparam int ATTR_W = 3;
    localparam int FCNT_W = 4;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXTEND_NINTH  = 3'd0,
        CFG_UNDERLINE_MOD = 3'd1,
        CFG_CURSOR_BLINKS = 3'd2,
        CFG_HIDE_ATTR     = 3'd3,
        CFG_HIDE_CTRL     = 3'd4,
        CFG_CURSOR_BLOCK  = 3'd5,
        CFG_INVERT_SCREEN = 3'd6
    } cfg_index_t;

    // Running attribute codes (bits 6..4 of an attribute byte)
    typedef enum logic [ATTR_W-1:0] {
        ATTR_NONE      = 3'd0,
        ATTR_NONE_ALT  = 3'd1,
        ATTR_LOW       = 3'd2,
        ATTR_BLINK     = 3'd3,
        ATTR_INVERSE   = 3'd4,
        ATTR_UNDERLINE = 3'd5,
        ATTR_INVISIBLE = 3'd6,
        ATTR_NONE_TOP  = 3'd7
    } attr_t;

    // Configuration register set
    typedef struct packed {
        logic extend_ninth_dot;
        logic underline_flag_mode;
        logic cursor_blinks;
        logic hide_attribute_bytes;
        logic hide_control_bytes;
        logic cursor_is_block;
        logic invert_whole_screen;
    } cfg_t;

    // One input word as held in the input register
    typedef struct packed {
        logic              frame_start;
        logic              cell_active;
        logic [BYTE_W-1:0] cell_byte;
        logic [BYTE_W-1:0] glyph_row;
        logic [LINE_W-1:0] line_index;
        logic              cursor_here;
        logic              video_on;
    } item_t;

    // Attribute state as seen by the current word
    typedef struct packed {
        attr_t attr;
        logic  blink;
    } attr_view_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcar_cfg_regs.sv
// Configuration register file for the text cell attribute renderer.
`default_nettype none

module tcar_cfg_regs (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire [tcar_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [tcar_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output tcar_pkg::cfg_t                      cfg
);
    import tcar_pkg::*;

    cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.extend_ninth_dot     <= 1'b1;
            cfg_reg.underline_flag_mode  <= 1'b0;
            cfg_reg.cursor_blinks        <= 1'b0;
            cfg_reg.hide_attribute_bytes <= 1'b1;
            cfg_reg.hide_control_bytes   <= 1'b1;
            cfg_reg.cursor_is_block      <= 1'b0;
            cfg_reg.invert_whole_screen  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_EXTEND_NINTH:  cfg_reg.extend_ninth_dot     <= cfg_wdata[0];
                CFG_UNDERLINE_MOD: cfg_reg.underline_flag_mode  <= cfg_wdata[0];
                CFG_CURSOR_BLINKS: cfg_reg.cursor_blinks        <= cfg_wdata[0];
                CFG_HIDE_ATTR:     cfg_reg.hide_attribute_bytes <= cfg_wdata[0];
                CFG_HIDE_CTRL:     cfg_reg.hide_control_bytes   <= cfg_wdata[0];
                CFG_CURSOR_BLOCK:  cfg_reg.cursor_is_block      <= cfg_wdata[0];
                CFG_INVERT_SCREEN: cfg_reg.invert_whole_screen  <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tcar_attr_track.sv
// Running attribute and frame counter, updated once per processed word.
`default_nettype none

module tcar_attr_track (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      step,
    input  wire tcar_pkg::item_t     item,
    input  wire                      underline_flag_mode,
    output tcar_pkg::attr_view_t     view
);
    import tcar_pkg::*;

    attr_t              attr_reg;
    attr_t              attr_next;
    attr_t              attr_eff;
    logic [FCNT_W-1:0]  fcnt_reg;
    logic [FCNT_W-1:0]  fcnt_eff;
    logic               load_attr;

    // Frame start clears the attribute and steps the counter before use
    assign fcnt_eff = item.frame_start ? fcnt_reg + FCNT_W'(1) : fcnt_reg;
    assign attr_eff = item.frame_start ? ATTR_NONE : attr_reg;

    // Attribute bytes load bits 6..4 in attribute mode with video on
    assign load_attr = item.cell_active && !underline_flag_mode && item.video_on
                       && item.cell_byte[7];
    assign attr_next = load_attr ? attr_t'(item.cell_byte[6:4]) : attr_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_NONE;
            fcnt_reg <= '0;
        end
        else if (step)
        begin
            attr_reg <= attr_next;
            fcnt_reg <= fcnt_eff;
        end
    end

    assign view.attr  = attr_eff;
    assign view.blink = fcnt_eff[FCNT_W-1];

`ifndef SYNTHESIS
    // State only moves when a word is processed
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(attr_reg) && $stable(fcnt_reg)))
        else $error("attribute state changed without a word");

    // Frame start steps the counter by one
    a_frame_step: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.frame_start) |=> (fcnt_reg == $past(fcnt_reg) + FCNT_W'(1)))
        else $error("frame counter did not step");

    // Without an attribute byte, frame start leaves the attribute cleared
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.frame_start && !load_attr) |=> (attr_reg == ATTR_NONE))
        else $error("frame start did not clear attribute");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/tcar_dot_logic.sv
// Combinational dot shaping: blanking, ninth dot, attributes, cursor, inverse.
`default_nettype none

module tcar_dot_logic (
    input  wire tcar_pkg::item_t            item,
    input  wire tcar_pkg::cfg_t             cfg,
    input  wire tcar_pkg::attr_view_t       view,
    output logic [tcar_pkg::DOTS_W-1:0]     dots,
    output logic                            high_intensity
);
    import tcar_pkg::*;

    logic              is_attr;
    logic              is_ctrl;
    logic              show_glyph;
    logic              last_line;
    logic              cursor_line;
    logic              cursor_on;
    logic [DOTS_W-1:0] base;
    logic [DOTS_W-1:0] shaped;
    logic              hi;

    // Byte class and line decode
    assign is_attr     = item.cell_byte[7];
    assign is_ctrl     = (item.cell_byte[6:5] == 2'b00);
    assign last_line   = (item.line_index == UNDERLINE_LINE);
    assign cursor_line = (item.line_index == CURSOR_LINE);
    assign show_glyph  = item.video_on && (!is_ctrl || !cfg.hide_control_bytes)
                         && !(is_attr && cfg.hide_attribute_bytes);
    assign cursor_on   = item.cursor_here && (cursor_line || cfg.cursor_is_block)
                         && (!cfg.cursor_blinks || view.blink);

    // Glyph with optional ninth-dot extension
    assign base = show_glyph
                  ? {item.glyph_row, cfg.extend_ninth_dot & item.glyph_row[0]}
                  : '0;

    // Attribute, underline and cursor effects
    always_comb
    begin
        shaped = base;
        hi     = 1'b1;
        if (cfg.underline_flag_mode)
        begin
            if (is_attr && last_line)
                shaped = '1;
        end
        else if (item.video_on && !is_attr)
        begin
            case (view.attr)
                ATTR_LOW:       hi = 1'b0;
                ATTR_BLINK:
                begin
                    if (view.blink && !item.cursor_here)
                        shaped = '0;
                end
                ATTR_INVERSE:   shaped = ~shaped;
                ATTR_UNDERLINE:
                begin
                    if (last_line)
                        shaped = '1;
                end
                ATTR_INVISIBLE: shaped = '0;
                default:        ;
            endcase
        end
        if (cursor_on)
            shaped = ~shaped;
        if (!item.cell_active)
        begin
            shaped = '0;
            hi     = 1'b1;
        end
        if (cfg.invert_whole_screen)
            shaped = ~shaped;
    end

    assign dots           = shaped;
    assign high_intensity = hi;

endmodule

`default_nettype wire

FILE: hw/rtl/text_cell_attribute_renderer_core.sv
// Top level of the text cell attribute renderer: input and result registers.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | frame_start cell_active cell_byte
//           |                      | glyph_row line_index cursor_here video_on
//   out     | out_valid / out_ready| dots high_intensity
//   cfg     | cfg_we               | cfg_index cfg_wdata
//
// A word is held in the input register and leaves through the result
// register; one word is taken every cycle unless the result stalls.
// The shaping logic between the two registers sets the clock period.
// Reset clears both valid flags, the attribute, the frame counter and the
// configuration to its defaults. A stalled result holds the input register,
// and in_ready drops only when both registers are full and out_ready is low.
`default_nettype none

module text_cell_attribute_renderer_core (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 frame_start,
    input  wire                                 cell_active,
    input  wire [tcar_pkg::BYTE_W-1:0]          cell_byte,
    input  wire [tcar_pkg::BYTE_W-1:0]          glyph_row,
    input  wire [tcar_pkg::LINE_W-1:0]          line_index,
    input  wire                                 cursor_here,
    input  wire                                 video_on,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [tcar_pkg::DOTS_W-1:0]         dots,
    output logic                                high_intensity,
    input  wire                                 cfg_we,
    input  wire [tcar_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [tcar_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import tcar_pkg::*;

    cfg_t               cfg;
    attr_view_t         view;
    item_t              s1_item_reg;
    logic               s1_valid_reg;
    logic               out_valid_reg;
    logic [DOTS_W-1:0]  dots_reg;
    logic               hi_reg;
    logic [DOTS_W-1:0]  dots_next;
    logic               hi_next;
    logic               out_free;
    logic               step;

    // Pipeline advance
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_free;
    assign step     = s1_valid_reg && out_free;

    tcar_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tcar_attr_track u_attr (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step                (step),
        .item                (s1_item_reg),
        .underline_flag_mode (cfg.underline_flag_mode),
        .view                (view)
    );

    tcar_dot_logic u_dots (
        .item           (s1_item_reg),
        .cfg            (cfg),
        .view           (view),
        .dots           (dots_next),
        .high_intensity (hi_next)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.frame_start <= frame_start;
            s1_item_reg.cell_active <= cell_active;
            s1_item_reg.cell_byte   <= cell_byte;
            s1_item_reg.glyph_row   <= glyph_row;
            s1_item_reg.line_index  <= line_index;
            s1_item_reg.cursor_here <= cursor_here;
            s1_item_reg.video_on    <= video_on;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            dots_reg <= dots_next;
            hi_reg   <= hi_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign dots           = dots_reg;
    assign high_intensity = hi_reg;

`ifndef SYNTHESIS
    // Input stalls only behind a full pipeline blocked at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without output backpressure");

    // A processed word always shows up as a result
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed word lost");

    // Inactive cells give dark dots at full intensity without screen inverse
    a_margin: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !s1_item_reg.cell_active && !cfg.invert_whole_screen)
        |=> (dots_reg == '0 && hi_reg))
        else $error("margin word not dark");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text cell attribute renderer core.

module tb;
    import tcar_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          DRAIN_CYCLES  = 4;
    localparam int          LONG_HOLD     = 40;
    localparam int          PHASES        = 8;
    localparam int          PHASE_WORDS   = 80;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;
    localparam cfg_t        CFG_DEFAULT   = 7'b1001100;
    localparam cfg_t        CFG_ALL_ON    = 7'b1111111;
    localparam cfg_t        CFG_ALL_OFF   = 7'b0000000;

    // One rendered segment as seen on the result channel
    typedef struct packed {
        logic [DOTS_W-1:0] dots;
        logic              high_intensity;
    } segment_t;

    // One row of the directed table
    typedef struct {
        bit       reconfig;
        cfg_t     cfg;
        item_t    word;
        bit       typed;
        segment_t want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   frame_start;
    logic                   cell_active;
    logic [BYTE_W-1:0]      cell_byte;
    logic [BYTE_W-1:0]      glyph_row;
    logic [LINE_W-1:0]      line_index;
    logic                   cursor_here;
    logic                   video_on;
    logic                   out_valid;
    logic                   out_ready;
    logic [DOTS_W-1:0]      dots;
    logic                   high_intensity;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Predictor state and the segments still owed by the block
    cfg_t        shade_cfg;
    attr_t       run_attr;
    logic [3:0]  frame_ctr;
    segment_t    pending_segments[$];
    stim_row_t   directed_rows[$];

    int          fault_count;
    int          cycle_count;
    int          src_idle_pct;
    int          sink_idle_pct;
    bit          hold_request;

    text_cell_attribute_renderer_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frame_start    (frame_start),
        .cell_active    (cell_active),
        .cell_byte      (cell_byte),
        .glyph_row      (glyph_row),
        .line_index     (line_index),
        .cursor_here    (cursor_here),
        .video_on       (video_on),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .dots           (dots),
        .high_intensity (high_intensity),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("text_cell_attribute_renderer_core verification failed");
            $finish;
        end
    end

    // Segment shaping: glyph blanking, attributes, cursor, screen inverse
    function automatic segment_t render_segment(input item_t w);
        logic [7:0] data;
        logic       ninth;
        logic       hi;
        logic       blink;
        logic       on_last;
        logic       on_cursor;
        logic       is_attr;
        logic       is_ctrl;
        segment_t   s;
        data  = '0;
        ninth = 1'b0;
        hi    = 1'b1;
        if (w.frame_start)
        begin
            run_attr  = ATTR_NONE;
            frame_ctr = frame_ctr + 4'd1;
        end
        blink     = frame_ctr[3];
        on_last   = (w.line_index == LINE_W'(CELL_LINES - 1));
        on_cursor = (w.line_index == LINE_W'(CELL_LINES - 2));
        if (w.cell_active)
        begin
            is_attr = w.cell_byte[7];
            is_ctrl = (w.cell_byte[6:5] == 2'b00);
            if (w.video_on && (!is_ctrl || !shade_cfg.hide_control_bytes)
                && !(is_attr && shade_cfg.hide_attribute_bytes))
            begin
                data  = w.glyph_row;
                ninth = shade_cfg.extend_ninth_dot & w.glyph_row[0];
            end
            if (shade_cfg.underline_flag_mode)
            begin
                if (is_attr && on_last)
                begin
                    data  = 8'hFF;
                    ninth = 1'b1;
                end
            end
            else if (w.video_on)
            begin
                if (is_attr)
                    run_attr = attr_t'(w.cell_byte[6:4]);
                else
                begin
                    case (run_attr)
                        ATTR_LOW:       hi = 1'b0;
                        ATTR_BLINK:
                        begin
                            // the cursor cell never blinks away
                            if (blink && !w.cursor_here)
                            begin
                                data  = '0;
                                ninth = 1'b0;
                            end
                        end
                        ATTR_INVERSE:
                        begin
                            data  = ~data;
                            ninth = ~ninth;
                        end
                        ATTR_UNDERLINE:
                        begin
                            if (on_last)
                            begin
                                data  = 8'hFF;
                                ninth = 1'b1;
                            end
                        end
                        ATTR_INVISIBLE:
                        begin
                            data  = '0;
                            ninth = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            if (w.cursor_here && (on_cursor || shade_cfg.cursor_is_block)
                && (!shade_cfg.cursor_blinks || blink))
            begin
                data  = ~data;
                ninth = ~ninth;
            end
        end
        if (shade_cfg.invert_whole_screen)
        begin
            data  = ~data;
            ninth = ~ninth;
        end
        s.dots           = {data, ninth};
        s.high_intensity = hi;
        return s;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_segments.size() == 0)
            begin
                $display("%0t: unexpected word dots %h high_intensity %b",
                         $time, dots, high_intensity);
                fault_count = fault_count + 1;
            end
            else
            begin
                want = pending_segments.pop_front();
                if (dots !== want.dots)
                begin
                    $display("%0t: dots expected %h actual %h", $time, want.dots, dots);
                    fault_count = fault_count + 1;
                end
                if (high_intensity !== want.high_intensity)
                begin
                    $display("%0t: high_intensity expected %b actual %b",
                             $time, want.high_intensity, high_intensity);
                    fault_count = fault_count + 1;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold on request
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                out_ready    = 1'b1;
                hold_request = 1'b0;
            end
            else if ($urandom_range(0, 99) < sink_idle_pct)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    // Offer one word, log its expected segment on acceptance
    task automatic send_word(input item_t w, input bit typed, input segment_t typed_seg);
        segment_t seg;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid    = 1'b1;
        frame_start = w.frame_start;
        cell_active = w.cell_active;
        cell_byte   = w.cell_byte;
        glyph_row   = w.glyph_row;
        line_index  = w.line_index;
        cursor_here = w.cursor_here;
        video_on    = w.video_on;
        do
            @(posedge clk);
        while (!in_ready);
        seg = render_segment(w);
        pending_segments.push_back(typed ? typed_seg : seg);
        @(negedge clk);
    endtask

    // Drop valid and wait until the block has drained
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_segments.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic v);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        @(negedge clk);
    endtask

    // Write every register, then poke the unused index
    task automatic apply_config(input cfg_t c);
        write_reg(CFG_EXTEND_NINTH,  c.extend_ninth_dot);
        write_reg(CFG_UNDERLINE_MOD, c.underline_flag_mode);
        write_reg(CFG_CURSOR_BLINKS, c.cursor_blinks);
        write_reg(CFG_HIDE_ATTR,     c.hide_attribute_bytes);
        write_reg(CFG_HIDE_CTRL,     c.hide_control_bytes);
        write_reg(CFG_CURSOR_BLOCK,  c.cursor_is_block);
        write_reg(CFG_INVERT_SCREEN, c.invert_whole_screen);
        write_reg(CFG_SPARE_INDEX,   ~c.invert_whole_screen);
        cfg_we    = 1'b0;
        shade_cfg = c;
    endtask

    task automatic add_row(input bit reconfig, input cfg_t c, input bit fs, input bit act,
                           input logic [7:0] b, input logic [7:0] g, input logic [3:0] ln,
                           input bit cur, input bit von, input bit typed,
                           input logic [8:0] d, input bit hi);
        stim_row_t r;
        r.reconfig                = reconfig;
        r.cfg                     = c;
        r.word.frame_start        = fs;
        r.word.cell_active        = act;
        r.word.cell_byte          = b;
        r.word.glyph_row          = g;
        r.word.line_index         = ln;
        r.word.cursor_here        = cur;
        r.word.video_on           = von;
        r.typed                   = typed;
        r.want.dots               = d;
        r.want.high_intensity     = hi;
        directed_rows.push_back(r);
    endtask

    // Mostly plausible raster traffic, some fully random noise
    function automatic item_t random_word();
        item_t w;
        if ($urandom_range(0, 99) < 85)
        begin
            w.frame_start = ($urandom_range(0, 11) == 0);
            w.cell_active = ($urandom_range(0, 9) != 0);
            case ($urandom_range(0, 9))
                0, 1:    w.cell_byte = {1'b1, 7'($urandom)};
                2:       w.cell_byte = {3'b000, 5'($urandom)};
                default: w.cell_byte = 8'($urandom_range(8'h20, 8'h7F));
            endcase
            w.glyph_row   = 8'($urandom);
            w.line_index  = 4'($urandom_range(0, CELL_LINES - 1));
            w.cursor_here = ($urandom_range(0, 7) == 0);
            w.video_on    = ($urandom_range(0, 15) != 0);
        end
        else
        begin
            w.frame_start = 1'($urandom);
            w.cell_active = 1'($urandom);
            w.cell_byte   = 8'($urandom);
            w.glyph_row   = 8'($urandom);
            w.line_index  = 4'($urandom);
            w.cursor_here = 1'($urandom);
            w.video_on    = 1'($urandom);
        end
        return w;
    endfunction

    // Main sequence
    initial
    begin
        cfg_t     c;
        segment_t none_seg;
        none_seg      = '0;
        fault_count   = 0;
        hold_request  = 1'b0;
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        shade_cfg     = CFG_DEFAULT;
        run_attr      = ATTR_NONE;
        frame_ctr     = '0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        frame_start   = 1'b0;
        cell_active   = 1'b0;
        cell_byte     = '0;
        glyph_row     = '0;
        line_index    = '0;
        cursor_here   = 1'b0;
        video_on      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table, reset configuration first
        add_row(0, CFG_DEFAULT, 0, 0, 8'hFF, 8'hFF, 0,  0, 1, 1, 9'h000, 1); // inactive
        add_row(0, CFG_DEFAULT, 0, 1, 8'h41, 8'h81, 0,  0, 1, 1, 9'h103, 1); // ninth dot
        add_row(0, CFG_DEFAULT, 0, 1, 8'h00, 8'hFF, 0,  0, 1, 1, 9'h000, 1); // control byte
        add_row(0, CFG_DEFAULT, 0, 1, 8'h20, 8'hFF, 0,  0, 0, 1, 9'h000, 1); // video off
        add_row(0, CFG_DEFAULT, 0, 1, 8'hA0, 8'hFF, 0,  0, 1, 1, 9'h000, 1); // set low int
        add_row(0, CFG_DEFAULT, 0, 1, 8'h41, 8'h3C, 0,  0, 1, 1, 9'h078, 0);
        add_row(0, CFG_DEFAULT, 0, 1, 8'hB0, 8'hFF, 0,  0, 1, 0, 9'h000, 1); // set blink
        add_row(0, CFG_DEFAULT, 0, 1, 8'h41, 8'h5A, 3,  0, 1, 0, 9'h000, 1);
        add_row(0, CFG_DEFAULT, 0, 1, 8'hC0, 8'hFF, 0,  0, 1, 0, 9'h000, 1); // set inverse
        add_row(0, CFG_DEFAULT, 0, 1, 8'h41, 8'h0F, 2,  0, 1, 0, 9'h000, 1);
        add_row(0, CFG_DEFAULT, 0, 1, 8'hD0, 8'hFF, 0,  0, 1, 0, 9'h000, 1); // set underline
        add_row(0, CFG_DEFAULT, 0, 1, 8'h41, 8'h00, 13, 0, 1, 0, 9'h000, 1);
        add_row(0, CFG_DEFAULT, 0, 1, 8'h41, 8'h00, 15, 0, 1, 0, 9'h000, 1); // past cell
        add_row(0, CFG_DEFAULT, 0, 1, 8'hE0, 8'hFF, 0,  0, 1, 0, 9'h000, 1); // set invisible
        add_row(0, CFG_DEFAULT, 0, 1, 8'h7E, 8'hFF, 4,  0, 1, 0, 9'h000, 1);
        add_row(0, CFG_DEFAULT, 1, 1, 8'h41, 8'h81, 12, 1, 1, 0, 9'h000, 1); // frame, cursor
        add_row(0, CFG_DEFAULT, 0, 1, 8'h41, 8'h81, 14, 1, 1, 0, 9'h000, 1);
        add_row(0, CFG_DEFAULT, 0, 1, 8'h90, 8'hFF, 0,  0, 1, 0, 9'h000, 1);
        add_row(0, CFG_DEFAULT, 0, 1, 8'h41, 8'hFF, 6,  0, 1, 0, 9'h000, 1);
        // Everything on: full inverse, underline mode, blinking block cursor
        add_row(1, CFG_ALL_ON,  0, 0, 8'h41, 8'hFF, 0,  1, 1, 1, 9'h1FF, 1);
        add_row(0, CFG_ALL_ON,  0, 1, 8'h80, 8'hFF, 13, 0, 0, 0, 9'h000, 1);
        add_row(0, CFG_ALL_ON,  0, 1, 8'h41, 8'h55, 3,  1, 1, 0, 9'h000, 1);
        // Everything off: nothing hidden, no ninth dot
        add_row(1, CFG_ALL_OFF, 0, 1, 8'h01, 8'hFF, 0,  0, 1, 1, 9'h1FE, 1);
        add_row(0, CFG_ALL_OFF, 0, 1, 8'hFF, 8'hFF, 0,  0, 1, 0, 9'h000, 1);
        add_row(0, CFG_ALL_OFF, 0, 1, 8'h41, 8'hFF, 5,  1, 1, 0, 9'h000, 1);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].reconfig)
            begin
                wait_idle();
                apply_config(directed_rows[i].cfg);
            end
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases, each under its own configuration
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:       c = CFG_ALL_OFF;
                1:       c = CFG_ALL_ON;
                default:
                begin
                    c = cfg_t'(7'($urandom));
                    c.underline_flag_mode = ($urandom_range(0, 2) == 0);
                end
            endcase
            apply_config(c);
            src_idle_pct  = (p == 3 || p == PHASES - 1) ? 0 : $urandom_range(5, 40);
            sink_idle_pct = (p == 3 || p == PHASES - 1) ? 0 : $urandom_range(5, 40);
            if (p == 2)
            begin
                // long receiver hold while words keep coming
                src_idle_pct = 0;
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_WORDS; n++)
                send_word(random_word(), 1'b0, none_seg);
        end

        wait_idle();
        repeat (10) @(negedge clk);
        if (fault_count == 0)
            $display("text_cell_attribute_renderer_core verification clean");
        else
            $display("text_cell_attribute_renderer_core verification failed");
        $finish;
    end

endmodule
